FILE: sv/cpsq_pkg.sv
`default_nettype none
package cpsq_pkg;
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Datapath commands issued by the controller and by the top module
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_APPEND,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_FETCH,
    CMD_DIFF,
    CMD_DOT,
    CMD_SQRT_START,
    CMD_SQRT_STEP,
    CMD_CROSS,
    CMD_CROSS_HI,
    CMD_DECIDE,
    CMD_RESULT_ZERO
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic fetch_done;
    logic sqrt_done;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         support_index;
    logic signed [31:0] support_x;
    logic signed [31:0] support_y;
    logic signed [31:0] edge_a_x;
    logic signed [31:0] edge_a_y;
    logic signed [31:0] edge_b_x;
    logic signed [31:0] edge_b_y;
  } result_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } request_t;
endpackage
`default_nettype wire

FILE: sv/cpsq_if.sv
`default_nettype none
interface cpsq_req_if;
  logic                     valid;
  logic                     ready;
  cpsq_pkg::request_t       data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpsq_res_if;
  logic                     valid;
  logic                     ready;
  cpsq_pkg::result_t        data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/cpsq_datapath.sv
`default_nettype none
module cpsq_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire cpsq_pkg::cmd_t  cmd,
  input  wire cpsq_pkg::request_t req,
  output cpsq_pkg::dp_status_t stat,
  output cpsq_pkg::result_t    res
);
  import cpsq_pkg::*;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [63:0] mem [MAX_VERTICES];
  logic [63:0] rdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;   // index whose read is being issued; arriving data is for scan_idx - 1
  logic          scan_vld;
  logic [AW-1:0] best;
  logic signed [49:0] best_dot;
  logic signed [15:0] dx, dy;
  logic [1:0] fetch_ph;
  logic signed [31:0] tx, ty, ax, ay, bx, by;
  logic signed [32:0] v0x, v0y, v1x, v1y;
  logic signed [49:0] d0, d1;
  // integer sqrt state, two lengths in parallel
  logic [67:0] n0, n1;
  logic [34:0] r0, r1;
  logic [5:0]  sbit;
  logic signed [85:0] p0, p1;
  logic [AW-1:0] last, cwi, ccwi;
  logic [1:0] zst;

  assign last = AW'(count - CW'(1));
  assign cwi  = (best == '0) ? last : best - AW'(1);
  assign ccwi = (best == last) ? '0 : best + AW'(1);

  // Vertex table, registered read
  always_ff @(posedge clk) begin
    if (cmd == CMD_APPEND && count < CW'(MAX_VERTICES)) begin
      mem[count[AW-1:0]] <= {req.vertex_x, req.vertex_y};
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    raddr = scan_idx[AW-1:0];
    if (cmd == CMD_FETCH) begin
      case (fetch_ph)
        2'd0: raddr = best;
        2'd1: raddr = cwi;
        default: raddr = ccwi;
      endcase
    end
  end

  // Per-vertex dot product
  logic signed [48:0] px, py;
  logic signed [49:0] dcur;
  assign px = $signed(rdata[63:32]) * dx;
  assign py = $signed(rdata[31:0]) * dy;
  assign dcur = 50'(px) + 50'(py);

  // Sqrt trial squares
  logic [34:0] t0, t1;
  logic [69:0] tq0, tq1;
  assign t0 = r0 | (35'd1 << sbit);
  assign t1 = r1 | (35'd1 << sbit);
  assign tq0 = t0 * t0;
  assign tq1 = t1 * t1;

  logic [32:0] m0x, m0y, m1x, m1y;
  assign m0x = v0x[32] ? 33'(-v0x) : 33'(v0x);
  assign m0y = v0y[32] ? 33'(-v0y) : 33'(v0y);
  assign m1x = v1x[32] ? 33'(-v1x) : 33'(v1x);
  assign m1y = v1y[32] ? 33'(-v1y) : 33'(v1y);

  // Edge dot products and squared lengths
  logic signed [48:0] e0x, e0y, e1x, e1y;
  logic [65:0] s0x, s0y, s1x, s1y;
  assign e0x = v0x * dx;
  assign e0y = v0y * dy;
  assign e1x = v1x * dx;
  assign e1y = v1y * dy;
  assign s0x = m0x * m0x;
  assign s0y = m0y * m0y;
  assign s1x = m1x * m1x;
  assign s1y = m1y * m1y;

  // Cross products, low half of the root first, then the high half added
  logic [17:0] rs0, rs1;
  logic signed [68:0] q0, q1;
  assign rs0 = (cmd == CMD_CROSS_HI) ? {1'b0, r0[34:18]} : r0[17:0];
  assign rs1 = (cmd == CMD_CROSS_HI) ? {1'b0, r1[34:18]} : r1[17:0];
  assign q0 = d0 * $signed({1'b0, rs1});
  assign q1 = d1 * $signed({1'b0, rs0});

  // Status code of a result that carries no geometry
  always_comb begin
    zst = ST_OK;
    if (req.req_type == REQ_QUERY) zst = ST_EMPTY;
    else if (req.req_type == REQ_APPEND && stat.full) zst = ST_FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      scan_vld <= 1'b0;
      scan_idx <= '0;
      fetch_ph <= '0;
      sbit <= '0;
    end else begin
      case (cmd)
        CMD_CLEAR: count <= '0;
        CMD_APPEND: if (count < CW'(MAX_VERTICES)) count <= count + CW'(1);
        CMD_SCAN_START: begin
          dx <= req.dir_x;
          dy <= req.dir_y;
          scan_idx <= '0;
          scan_vld <= 1'b0;
          fetch_ph <= '0;
        end
        CMD_SCAN_STEP: begin
          // read issued for scan_idx; data of the previous index compared here
          scan_vld <= 1'b1;
          if (scan_vld) begin
            if (scan_idx == CW'(1) || dcur > best_dot) begin
              best_dot <= dcur;
              best <= AW'(scan_idx - CW'(1));
            end
          end
          scan_idx <= scan_idx + CW'(1);
        end
        CMD_FETCH: begin
          fetch_ph <= fetch_ph + 2'd1;
          case (fetch_ph)
            2'd1: begin tx <= $signed(rdata[63:32]); ty <= $signed(rdata[31:0]); end
            2'd2: begin ax <= $signed(rdata[63:32]); ay <= $signed(rdata[31:0]); end
            2'd3: begin bx <= $signed(rdata[63:32]); by <= $signed(rdata[31:0]); end
            default: ;
          endcase
        end
        CMD_DIFF: begin
          v0x <= 33'(ax) - 33'(tx);
          v0y <= 33'(ay) - 33'(ty);
          v1x <= 33'(bx) - 33'(tx);
          v1y <= 33'(by) - 33'(ty);
        end
        CMD_DOT: begin
          d0 <= 50'(e0x) + 50'(e0y);
          d1 <= 50'(e1x) + 50'(e1y);
          n0 <= 68'(s0x) + 68'(s0y);
          n1 <= 68'(s1x) + 68'(s1y);
        end
        CMD_SQRT_START: begin
          r0 <= '0;
          r1 <= '0;
          sbit <= 6'd34;
        end
        CMD_SQRT_STEP: begin
          if (70'(n0) >= tq0) r0 <= t0;
          if (70'(n1) >= tq1) r1 <= t1;
          sbit <= sbit - 6'd1;
        end
        CMD_CROSS: begin
          p0 <= 86'(q0);
          p1 <= 86'(q1);
        end
        CMD_CROSS_HI: begin
          p0 <= p0 + (86'(q0) <<< 18);
          p1 <= p1 + (86'(q1) <<< 18);
        end
        CMD_DECIDE: begin
          res.status <= ST_OK;
          res.support_index <= 6'(best);
          res.support_x <= tx;
          res.support_y <= ty;
          if (p0 > p1) begin
            res.edge_a_x <= ax; res.edge_a_y <= ay;
            res.edge_b_x <= tx; res.edge_b_y <= ty;
          end else begin
            res.edge_a_x <= tx; res.edge_a_y <= ty;
            res.edge_b_x <= bx; res.edge_b_y <= by;
          end
        end
        CMD_RESULT_ZERO: begin
          res.status <= zst;
          res.support_index <= '0;
          res.support_x <= '0;
          res.support_y <= '0;
          res.edge_a_x <= '0;
          res.edge_a_y <= '0;
          res.edge_b_x <= '0;
          res.edge_b_y <= '0;
        end
        default: ;
      endcase
    end
  end

  assign stat.full = count >= CW'(MAX_VERTICES);
  assign stat.empty = count == '0;
  assign stat.scan_done = scan_vld && scan_idx == count;
  assign stat.fetch_done = fetch_ph == 2'd3;
  assign stat.sqrt_done = sbit == 6'd0;
endmodule
`default_nettype wire

FILE: sv/cpsq_ctrl.sv
`default_nettype none
module cpsq_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [1:0]                 req_type,
  output logic                      out_valid,
  input  wire                       out_ready,
  input  wire cpsq_pkg::dp_status_t stat,
  output cpsq_pkg::cmd_t            cmd
);
  import cpsq_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FETCH, S_DIFF, S_DOT, S_SQ0, S_SQ, S_CROSS, S_CROSS2, S_DEC, S_OUT
  } state_t;
  state_t state;
  logic [1:0] rq;

  assign in_ready = (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd = CMD_NONE;
    case (state)
      S_IDLE: cmd = CMD_NONE;
      S_SCAN: cmd = CMD_SCAN_STEP;
      S_FETCH: cmd = CMD_FETCH;
      S_DIFF: cmd = CMD_DIFF;
      S_DOT: cmd = CMD_DOT;
      S_SQ0: cmd = CMD_SQRT_START;
      S_SQ: cmd = CMD_SQRT_STEP;
      S_CROSS: cmd = CMD_CROSS;
      S_CROSS2: cmd = CMD_CROSS_HI;
      S_DEC: cmd = CMD_DECIDE;
      default: cmd = CMD_NONE;
    endcase
    if (state == S_IDLE && in_valid) begin
      if (req_type == REQ_QUERY && !stat.empty) cmd = CMD_SCAN_START;
      else cmd = CMD_RESULT_ZERO;
    end
    if (state == S_OUT && rq != REQ_UNUSED) begin
      // zero result for bookkeeping requests was set in idle
      cmd = CMD_NONE;
    end
  end

  // State register; the datapath sees req live, so bookkeeping updates
  // happen through a second command in the output state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rq <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          rq <= req_type;
          if (req_type == REQ_QUERY && !stat.empty) state <= S_SCAN;
          else begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_SCAN: if (stat.scan_done) state <= S_FETCH;
        S_FETCH: if (stat.fetch_done) state <= S_DIFF;
        S_DIFF: state <= S_DOT;
        S_DOT: state <= S_SQ0;
        S_SQ0: state <= S_SQ;
        S_SQ: if (stat.sqrt_done) state <= S_CROSS;
        S_CROSS: state <= S_CROSS2;
        S_CROSS2: state <= S_DEC;
        S_DEC: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/convex_polygon_support_query.sv
// Convex polygon support query.
// in_ch carries requests: clear (0), append vertex (1), support query (2);
// code 3 is answered with a zero result and no state change.
// out_ch carries exactly one result per request.
// One request is in flight at a time; in_ch.ready is high only when idle.
// Clear and append: the result is valid in the cycle after acceptance.
// A query runs a scan of the table over the single read port, a fetch of
// the support vertex and its neighbors, differences, dots and root setup,
// 35 iterations of the shared two-lane integer square root, and the edge
// decision (cross multiply by the low then the high root half, and the compare).
// The result register holds while out_ch.ready is low; no new request
// is taken until it is delivered.
// Reset empties the table (vertex count to zero); table contents are not
// cleared. An append to a full table is dropped and flagged.
`default_nettype none
module convex_polygon_support_query #(
  parameter int MAX_VERTICES = 64
) (
  input wire clk,
  input wire rst,
  cpsq_req_if.sink   in_ch,
  cpsq_res_if.source out_ch
);
  import cpsq_pkg::*;
  cmd_t cmd, cmd_c;
  dp_status_t stat;
  logic [1:0] rq;

  cpsq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .req_type(in_ch.data.req_type),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd(cmd_c)
  );

  // Bookkeeping requests are marked on acceptance; the table count is updated afterwards
  always_comb begin
    cmd = cmd_c;
    if (cmd_c == CMD_RESULT_ZERO) rq = in_ch.data.req_type;
    else rq = REQ_UNUSED;
  end

  // Result zeroing and count update share the accept cycle; sequence them
  cmd_t cmd2;
  logic pend_clear, pend_app;
  request_t held;
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_clear <= 1'b0;
      pend_app <= 1'b0;
    end else begin
      pend_clear <= (rq == REQ_CLEAR);
      pend_app <= (rq == REQ_APPEND);
    end
    if (cmd_c == CMD_RESULT_ZERO) held <= in_ch.data;
  end
  always_comb begin
    cmd2 = cmd;
    if (pend_clear) cmd2 = CMD_CLEAR;
    else if (pend_app) cmd2 = CMD_APPEND;
  end

  cpsq_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk, .rst, .cmd(cmd2),
    .req((pend_clear || pend_app) ? held : in_ch.data),
    .stat, .res(out_ch.data)
  );
endmodule
`default_nettype wire

FILE: sv/cpsq_checker.sv
`default_nettype none
module cpsq_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire [1:0] status
);
  // one request in flight: no accept while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped under stall");
  a_code: assert property (@(posedge clk) disable iff (rst) out_valid |-> status != 2'd3)
    else $error("bad status");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind convex_polygon_support_query cpsq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.data.status)
);
`default_nettype wire

FILE: tb/sv/convex_polygon_support_query_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module convex_polygon_support_query_tb;
  import cpsq_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 200;

  logic clk;
  logic rst;

  cpsq_req_if req_ch ();
  cpsq_res_if res_ch ();

  convex_polygon_support_query #(.MAX_VERTICES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch.sink),
    .out_ch(res_ch.source)
  );

  // Predictor state: own copy of the vertex table
  logic signed [31:0] poly_x [TABLE_DEPTH];
  logic signed [31:0] poly_y [TABLE_DEPTH];
  int unsigned        poly_count;

  request_t pending_reqs [$];
  result_t  expected_results [$];
  int       mismatches;
  int       idle_cycles;
  bit       no_idling;
  bit       hold_sender;
  int       send_gap;
  int       recv_gap;

  // floor(sqrt(dx^2 + dy^2)), exact over 67-bit squares
  function automatic logic [63:0] edge_length(logic signed [33:0] dx, logic signed [33:0] dy);
    logic [127:0] sq;
    logic [63:0]  root;
    logic [63:0]  trial;
    sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= sq) root = trial;
    end
    return root;
  endfunction

  // Apply one request to the predictor and return the expected result
  function automatic result_t predict_support(request_t rq);
    result_t r;
    logic signed [63:0]  best_dot, dot;
    logic signed [33:0]  v0x, v0y, v1x, v1y;
    logic signed [63:0]  d0, d1;
    logic [63:0]         l0, l1;
    logic signed [129:0] lhs, rhs;
    int unsigned best, cw, ccw;
    r = '0;
    case (rq.req_type)
      REQ_CLEAR: poly_count = 0;
      REQ_APPEND: begin
        if (poly_count < TABLE_DEPTH) begin
          poly_x[poly_count] = rq.vertex_x;
          poly_y[poly_count] = rq.vertex_y;
          poly_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_QUERY: begin
        if (poly_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          best_dot = 0;
          for (int unsigned i = 0; i < poly_count; i++) begin
            dot = 64'(poly_x[i]) * 64'(rq.dir_x) + 64'(poly_y[i]) * 64'(rq.dir_y);
            if (i == 0 || dot > best_dot) begin
              best_dot = dot;
              best = i;
            end
          end
          cw  = (best == 0) ? poly_count - 1 : best - 1;
          ccw = (best == poly_count - 1) ? 0 : best + 1;
          v0x = 34'(poly_x[cw]) - 34'(poly_x[best]);
          v0y = 34'(poly_y[cw]) - 34'(poly_y[best]);
          v1x = 34'(poly_x[ccw]) - 34'(poly_x[best]);
          v1y = 34'(poly_y[ccw]) - 34'(poly_y[best]);
          d0 = 64'(rq.dir_x) * 64'(v0x) + 64'(rq.dir_y) * 64'(v0y);
          d1 = 64'(rq.dir_x) * 64'(v1x) + 64'(rq.dir_y) * 64'(v1y);
          l0 = edge_length(v0x, v0y);
          l1 = edge_length(v1x, v1y);
          lhs = 130'(d0) * $signed({66'd0, l1});
          rhs = 130'(d1) * $signed({66'd0, l0});
          r.support_index = best[5:0];
          r.support_x = poly_x[best];
          r.support_y = poly_y[best];
          if (lhs > rhs) begin
            r.edge_a_x = poly_x[cw];
            r.edge_a_y = poly_y[cw];
            r.edge_b_x = poly_x[best];
            r.edge_b_y = poly_y[best];
          end else begin
            r.edge_a_x = poly_x[best];
            r.edge_a_y = poly_y[best];
            r.edge_b_x = poly_x[ccw];
            r.edge_b_y = poly_y[ccw];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold item
    end else if (send_gap > 0) begin
      req_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0 && !hold_sender
                 && !(expected_results.size() > 0 && req_ch.valid)) begin
      if (!no_idling && $urandom_range(0, 9) == 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= $urandom_range(0, 16);
      end else begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap > 0) begin
      res_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!no_idling && $urandom_range(0, 7) == 0) begin
      res_ch.ready <= 1'b0;
      recv_gap <= $urandom_range(0, 16);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(predict_support(req_ch.data));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", res_ch.data);
        end else begin
          exp_r = expected_results.pop_front();
          if (res_ch.data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_r, res_ch.data);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst && idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic request_t make_req(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                                        logic [15:0] ddx, logic [15:0] ddy);
    request_t rq;
    rq.req_type = kind;
    rq.vertex_x = x;
    rq.vertex_y = y;
    rq.dir_x = ddx;
    rq.dir_y = ddy;
    return rq;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Random convex-ish polygon: points on a circle, sometimes with duplicates
  task automatic push_polygon(int unsigned n, int radius);
    real a;
    for (int unsigned i = 0; i < n; i++) begin
      a = 6.2831853 * i / n;
      if (i > 0 && $urandom_range(0, 15) == 0)
        pending_reqs.push_back(pending_reqs[$]);
      else
        pending_reqs.push_back(make_req(REQ_APPEND, $rtoi(radius * $cos(a)),
                                        $rtoi(radius * $sin(a)), 0, 0));
    end
  endtask

  task automatic push_queries(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      pending_reqs.push_back(make_req(REQ_QUERY, $urandom(), $urandom(),
                                      rand_dir(), rand_dir()));
  endtask

  initial begin
    int unsigned n;
    mismatches = 0;
    idle_cycles = 0;
    poly_count = 0;
    no_idling = 0;
    hold_sender = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty query, single vertex, extremes, code 3, full table
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 16'h4000, 0));
    pending_reqs.push_back(make_req(REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 16'h8000, 16'h7FFF));
    pending_reqs.push_back(make_req(REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_reqs.push_back(make_req(REQ_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 16'h8000, 16'h8000));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 16'hFFFF, 16'h0001));
    pending_reqs.push_back(make_req(REQ_CLEAR, 32'hFFFF_FFFF, 0, 16'hFFFF, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 16'h4000, 0));
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      pending_reqs.push_back(make_req(REQ_APPEND, 32'd5, 32'd5, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 16'h1234, 16'hEDCB));
    pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0));

    // Random: polygons of mostly small size, queries, and noise
    while (pending_reqs.size() < 700) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) begin
        for (int unsigned i = 0; i < n; i++)
          pending_reqs.push_back(make_req(REQ_APPEND, rand_coord(), rand_coord(), 0, 0));
      end else begin
        push_polygon(n, ($urandom_range(0, 1) == 0) ? 1000 : 2000000000);
      end
      push_queries($urandom_range(1, 8));
      if ($urandom_range(0, 5) == 0)
        pending_reqs.push_back(make_req(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                                        16'($urandom()), 16'($urandom())));
      pending_reqs.push_back(make_req(REQ_CLEAR, $urandom(), $urandom(),
                                      16'($urandom()), 16'($urandom())));
    end

    // Sender holds until every expected result is back
    wait (pending_reqs.size() < 400);
    hold_sender = 1;
    wait (expected_results.size() == 0 && !req_ch.valid);
    hold_sender = 0;

    // Last part: idling stops once fewer than 120 requests remain
    push_polygon(6, 50000);
    push_queries(150);
    wait (pending_reqs.size() < 120);
    no_idling = 1;
    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
sv/cpsq_pkg.sv
sv/cpsq_if.sv
sv/cpsq_datapath.sv
sv/cpsq_ctrl.sv
sv/convex_polygon_support_query.sv
sv/cpsq_checker.sv
tb/sv/convex_polygon_support_query_tb.sv
